@@ sv/adsr_pkg.sv @@
package adsr_pkg;

    typedef enum logic [2:0] {
        PH_ATTACK  = 3'd0,
        PH_DECAY   = 3'd1,
        PH_SUSTAIN = 3'd2,
        PH_RELEASE = 3'd3,
        PH_END     = 3'd4
    } t_phase;

    localparam logic [1:0] KIND_ADVANCE  = 2'd0;
    localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
    localparam logic [1:0] KIND_NOTE_OFF = 2'd2;

    localparam logic [2:0] CFG_ATTACK  = 3'd0;
    localparam logic [2:0] CFG_DECAY   = 3'd1;
    localparam logic [2:0] CFG_SUSTAIN = 3'd2;
    localparam logic [2:0] CFG_RELEASE = 3'd3;
    localparam logic [2:0] CFG_SUS_LVL = 3'd4;
    localparam logic [2:0] CFG_SQUARE  = 3'd5;

    localparam int GAIN_BITS = 15;
    localparam int FRAC_BITS = 16;
    localparam int ACC_BITS  = GAIN_BITS + FRAC_BITS;
    localparam int INC_BITS  = 32;
    localparam int CNT_BITS  = 24;

    localparam logic [GAIN_BITS-1:0] FULL_Q15 = 15'h7FFF;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_START_ATTACK,
        OP_START_DECAY,
        OP_START_RELEASE,
        OP_ENTER_SUSTAIN,
        OP_ENTER_END,
        OP_CLR_REM,
        OP_TRIM,
        OP_ACCUM,
        OP_SQUARE,
        OP_LOAD_OUT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        t_phase phase;
        logic   rem_zero;
        logic   sus_hold;
        logic   square_on;
        logic   div_busy;
        logic   out_full;
    } t_sts;

endpackage

@@ sv/adsr_envelope_generator.sv @@
// channel   direction  handshake            payload
// input     in         i_valid / o_ready    i_kind, i_sample_count
// output    out        o_valid / i_ready    o_gain, o_phase_at_entry, o_phase_now
// config    in         i_cfg_wr_en          i_cfg_index, i_cfg_data
//
// One item at a time. Kind three goes straight to the output register; an advance inside
// a phase trims the remaining length, accumulates and optionally squares the level.
// Each phase start with a nonzero length runs the bit-serial divider before it goes on.
// Synchronous active-low reset leaves the envelope in the end phase with zero gain.
// A finished item waits in the output register; the next item is accepted meanwhile.
module adsr_envelope_generator #(
    parameter int DURATION_BITS = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [2:0]   i_cfg_index,
    input  logic [23:0]  i_cfg_data,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [1:0]   i_kind,
    input  logic [23:0]  i_sample_count,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [14:0]  o_gain,
    output logic [2:0]   o_phase_at_entry,
    output logic [2:0]   o_phase_now
);

    adsr_pkg::t_cmd w_cmd;
    adsr_pkg::t_sts w_sts;
    logic           w_accept;

    assign w_accept = i_valid && o_ready;

    adsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_kind      (i_kind),
        .o_ready     (o_ready),
        .i_out_ready (i_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    adsr_dp #(.DB(DURATION_BITS)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_accept         (w_accept),
        .i_sample_count   (i_sample_count),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_out_ready      (i_ready),
        .o_out_valid      (o_valid),
        .o_gain           (o_gain),
        .o_phase_at_entry (o_phase_at_entry),
        .o_phase_now      (o_phase_now)
    );

endmodule

@@ sv/adsr_div.sv @@
module adsr_div #(
    parameter int DB = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [adsr_pkg::ACC_BITS-1:0]  i_dividend,
    input  logic [DB-1:0]                  i_divisor,
    output logic                           o_busy,
    output logic                           o_done,
    output logic [adsr_pkg::ACC_BITS-1:0]  o_quotient
);

    localparam int NB = adsr_pkg::ACC_BITS;
    localparam int CW = $clog2(NB);

    logic [DB:0]     r_rem;
    logic [NB-1:0]   r_quo;
    logic [DB-1:0]   r_den;
    logic [CW-1:0]   r_cnt;
    logic            r_busy;
    logic            r_done;

    logic [DB:0]     w_shift;
    logic [DB:0]     w_diff;
    logic            w_ge;

    assign w_shift = {r_rem[DB-1:0], r_quo[NB-1]};
    assign w_ge    = w_shift >= {1'b0, r_den};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NB - 1);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_den  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff : w_shift;
                r_quo <= {r_quo[NB-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ sv/adsr_dp.sv @@
module adsr_dp #(
    parameter int DB = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [2:0]                      i_cfg_index,
    input  logic [23:0]                     i_cfg_data,
    input  logic                            i_accept,
    input  logic [adsr_pkg::CNT_BITS-1:0]   i_sample_count,
    input  adsr_pkg::t_cmd                  i_cmd,
    output adsr_pkg::t_sts                  o_sts,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [adsr_pkg::GAIN_BITS-1:0]  o_gain,
    output logic [2:0]                      o_phase_at_entry,
    output logic [2:0]                      o_phase_now
);

    localparam int GB = adsr_pkg::GAIN_BITS;
    localparam int FB = adsr_pkg::FRAC_BITS;
    localparam int AB = adsr_pkg::ACC_BITS;
    localparam int IB = adsr_pkg::INC_BITS;
    localparam int CB = adsr_pkg::CNT_BITS;
    localparam int MW = (DB > CB) ? DB : CB;
    localparam int PW = IB + DB + 1;
    localparam int SW = PW + 1;

    logic [DB-1:0]          r_attack_len, r_decay_len, r_sustain_len, r_release_len;
    logic [GB-1:0]          r_sus_level;
    logic                   r_square;

    adsr_pkg::t_phase       r_phase, r_entry;
    logic [DB-1:0]          r_remaining;
    logic [AB-1:0]          r_acc;
    logic signed [IB-1:0]   r_inc;
    logic [GB-1:0]          r_level;
    logic                   r_neg;
    logic [CB-1:0]          r_count;
    logic signed [PW-1:0]   r_prod;

    logic                   r_out_valid;
    logic [GB-1:0]          r_out_gain;
    adsr_pkg::t_phase       r_out_entry, r_out_phase;

    logic                   w_div_start, w_div_busy, w_div_done, w_neg;
    logic [AB-1:0]          w_div_num, w_div_q;
    logic [DB-1:0]          w_div_den;

    logic [AB-1:0]          w_sus_acc, w_full_acc, w_lvl_acc;
    logic                   w_take_rem;
    logic [DB-1:0]          w_used, w_rem_next;
    logic signed [PW-1:0]   w_prod;
    logic signed [SW-1:0]   w_sum, w_sus_s, w_full_s, w_clamp;
    logic [2*GB-1:0]        w_sq;

    assign w_sus_acc  = {r_sus_level, {FB{1'b0}}};
    assign w_full_acc = {adsr_pkg::FULL_Q15, {FB{1'b0}}};
    assign w_lvl_acc  = {r_level, {FB{1'b0}}};

    always_comb begin
        w_div_start = 1'b0;
        w_div_num   = '0;
        w_div_den   = '0;
        w_neg       = 1'b0;
        case (i_cmd.op)
            adsr_pkg::OP_START_ATTACK: begin
                w_div_den   = r_attack_len;
                w_div_num   = w_full_acc;
                w_div_start = r_attack_len != '0;
            end
            adsr_pkg::OP_START_DECAY: begin
                w_div_den   = r_decay_len;
                w_neg       = r_level > r_sus_level;
                w_div_num   = w_neg ? {r_level - r_sus_level, {FB{1'b0}}}
                                    : {r_sus_level - r_level, {FB{1'b0}}};
                w_div_start = r_decay_len != '0;
            end
            adsr_pkg::OP_START_RELEASE: begin
                w_div_den   = r_release_len;
                w_div_num   = w_lvl_acc;
                w_neg       = 1'b1;
                w_div_start = r_release_len != '0;
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    adsr_div #(.DB(DB)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_num),
        .i_divisor  (w_div_den),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    assign w_take_rem = MW'(r_count) >= MW'(r_remaining);
    assign w_used     = w_take_rem ? r_remaining : DB'(r_count);
    assign w_rem_next = w_take_rem ? '0 : r_remaining - DB'(r_count);
    assign w_prod     = r_inc * $signed({1'b0, w_used});

    assign w_sum    = $signed(SW'({1'b0, r_acc})) + SW'(r_prod);
    assign w_sus_s  = $signed(SW'({1'b0, w_sus_acc}));
    assign w_full_s = $signed(SW'({1'b0, w_full_acc}));

    always_comb begin
        w_clamp = w_sum;
        if (r_phase == adsr_pkg::PH_DECAY) begin
            if (r_inc < 0 && w_clamp < w_sus_s) begin
                w_clamp = w_sus_s;
            end else if (r_inc > 0 && w_clamp > w_sus_s) begin
                w_clamp = w_sus_s;
            end
        end
        if (w_clamp < 0) begin
            w_clamp = '0;
        end
        if (w_clamp > w_full_s) begin
            w_clamp = w_full_s;
        end
    end

    assign w_sq = r_level * r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack_len  <= '0;
            r_decay_len   <= '0;
            r_sustain_len <= '0;
            r_release_len <= '0;
            r_sus_level   <= '0;
            r_square      <= 1'b0;
            r_phase       <= adsr_pkg::PH_END;
            r_entry       <= adsr_pkg::PH_END;
            r_remaining   <= '0;
            r_acc         <= '0;
            r_inc         <= '0;
            r_level       <= '0;
            r_neg         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    adsr_pkg::CFG_ATTACK:  r_attack_len  <= DB'(i_cfg_data);
                    adsr_pkg::CFG_DECAY:   r_decay_len   <= DB'(i_cfg_data);
                    adsr_pkg::CFG_SUSTAIN: r_sustain_len <= DB'(i_cfg_data);
                    adsr_pkg::CFG_RELEASE: r_release_len <= DB'(i_cfg_data);
                    adsr_pkg::CFG_SUS_LVL: r_sus_level   <= i_cfg_data[GB-1:0];
                    adsr_pkg::CFG_SQUARE:  r_square      <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (i_accept) begin
                r_entry <= r_phase;
                r_count <= i_sample_count;
            end

            if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (w_div_done) begin
                r_inc <= r_neg ? -$signed({1'b0, w_div_q}) : $signed({1'b0, w_div_q});
            end

            if (w_div_start) begin
                r_neg <= w_neg;
            end

            case (i_cmd.op)
                adsr_pkg::OP_START_ATTACK: begin
                    r_phase     <= adsr_pkg::PH_ATTACK;
                    r_remaining <= r_attack_len;
                    r_inc       <= '0;
                    if (r_attack_len != '0) begin
                        r_acc   <= '0;
                        r_level <= '0;
                    end else begin
                        r_acc   <= w_full_acc;
                        r_level <= adsr_pkg::FULL_Q15;
                    end
                end
                adsr_pkg::OP_START_DECAY: begin
                    r_phase     <= adsr_pkg::PH_DECAY;
                    r_remaining <= r_decay_len;
                    r_inc       <= '0;
                    if (r_decay_len != '0) begin
                        r_acc <= w_lvl_acc;
                    end else begin
                        r_acc   <= w_sus_acc;
                        r_level <= r_sus_level;
                    end
                end
                adsr_pkg::OP_START_RELEASE: begin
                    r_phase     <= adsr_pkg::PH_RELEASE;
                    r_remaining <= r_release_len;
                    r_inc       <= '0;
                    if (r_release_len != '0) begin
                        r_acc <= w_lvl_acc;
                    end else begin
                        r_acc   <= '0;
                        r_level <= '0;
                    end
                end
                adsr_pkg::OP_ENTER_SUSTAIN: begin
                    r_phase     <= adsr_pkg::PH_SUSTAIN;
                    r_remaining <= r_sustain_len;
                    r_acc       <= w_sus_acc;
                    r_inc       <= '0;
                    r_level     <= r_sus_level;
                end
                adsr_pkg::OP_ENTER_END: begin
                    r_phase     <= adsr_pkg::PH_END;
                    r_remaining <= '0;
                    r_acc       <= '0;
                    r_inc       <= '0;
                    r_level     <= '0;
                end
                adsr_pkg::OP_CLR_REM: begin
                    r_remaining <= '0;
                end
                adsr_pkg::OP_TRIM: begin
                    r_remaining <= w_rem_next;
                    r_prod      <= w_prod;
                end
                adsr_pkg::OP_ACCUM: begin
                    if (r_phase == adsr_pkg::PH_SUSTAIN) begin
                        r_level <= r_sus_level;
                    end else begin
                        r_acc   <= w_clamp[AB-1:0];
                        r_level <= w_clamp[AB-1:FB];
                    end
                end
                adsr_pkg::OP_SQUARE: begin
                    r_level <= w_sq[2*GB-1:GB];
                end
                adsr_pkg::OP_LOAD_OUT: begin
                    r_out_valid <= 1'b1;
                    r_out_gain  <= r_level;
                    r_out_entry <= r_entry;
                    r_out_phase <= r_phase;
                end
                default: ;
            endcase
        end
    end

    assign o_sts.phase     = r_phase;
    assign o_sts.rem_zero  = r_remaining == '0;
    assign o_sts.sus_hold  = r_sustain_len == '0;
    assign o_sts.square_on = r_square;
    assign o_sts.div_busy  = w_div_busy;
    assign o_sts.out_full  = r_out_valid;

    assign o_out_valid      = r_out_valid;
    assign o_gain           = r_out_gain;
    assign o_phase_at_entry = r_out_entry;
    assign o_phase_now      = r_out_phase;

endmodule

@@ sv/adsr_ctrl.sv @@
module adsr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [1:0]      i_kind,
    output logic            o_ready,
    input  logic            i_out_ready,
    input  adsr_pkg::t_sts  i_sts,
    output adsr_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_ADV_CHK,
        S_SETTLE,
        S_DIV_WAIT,
        S_ACCUM,
        S_SQUARE,
        S_FINISH
    } t_state;

    t_state          r_state;
    logic [1:0]      r_kind;
    logic            r_adv;
    adsr_pkg::t_cmd  r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_kind   <= adsr_pkg::KIND_ADVANCE;
            r_adv    <= 1'b0;
            r_cmd.op <= adsr_pkg::OP_NONE;
        end else begin
            r_cmd.op <= adsr_pkg::OP_NONE;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_kind  <= i_kind;
                        r_state <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    r_adv <= 1'b0;
                    case (r_kind)
                        adsr_pkg::KIND_ADVANCE: begin
                            r_adv   <= 1'b1;
                            r_state <= S_ADV_CHK;
                        end
                        adsr_pkg::KIND_NOTE_ON: begin
                            r_cmd.op <= adsr_pkg::OP_START_ATTACK;
                            r_state  <= S_SETTLE;
                        end
                        adsr_pkg::KIND_NOTE_OFF: begin
                            r_cmd.op <= adsr_pkg::OP_START_RELEASE;
                            r_state  <= S_SETTLE;
                        end
                        default: r_state <= S_FINISH;
                    endcase
                end
                S_ADV_CHK: begin
                    if (i_sts.phase == adsr_pkg::PH_END) begin
                        r_cmd.op <= adsr_pkg::OP_CLR_REM;
                        r_state  <= S_FINISH;
                    end else if (!i_sts.rem_zero ||
                                 (i_sts.phase == adsr_pkg::PH_SUSTAIN && i_sts.sus_hold)) begin
                        r_cmd.op <= adsr_pkg::OP_TRIM;
                        r_state  <= S_ACCUM;
                    end else begin
                        r_state <= S_SETTLE;
                        case (i_sts.phase)
                            adsr_pkg::PH_ATTACK:  r_cmd.op <= adsr_pkg::OP_START_DECAY;
                            adsr_pkg::PH_DECAY:   r_cmd.op <= adsr_pkg::OP_ENTER_SUSTAIN;
                            adsr_pkg::PH_SUSTAIN: r_cmd.op <= adsr_pkg::OP_START_RELEASE;
                            default:              r_cmd.op <= adsr_pkg::OP_ENTER_END;
                        endcase
                    end
                end
                S_SETTLE: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (!i_sts.div_busy) begin
                        r_state <= r_adv ? S_ADV_CHK : S_FINISH;
                    end
                end
                S_ACCUM: begin
                    r_cmd.op <= adsr_pkg::OP_ACCUM;
                    r_state  <= S_SQUARE;
                end
                S_SQUARE: begin
                    if (i_sts.square_on) begin
                        r_cmd.op <= adsr_pkg::OP_SQUARE;
                    end
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (!i_sts.out_full || i_out_ready) begin
                        r_cmd.op <= adsr_pkg::OP_LOAD_OUT;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready = r_state == S_IDLE;
    assign o_cmd   = r_cmd;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import adsr_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int SETTLE_CYCLES = 120;
    localparam longint FULL_ACC = longint'(FULL_Q15) <<< FRAC_BITS;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [23:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_kind = '0;
    logic [23:0] i_sample_count = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [14:0] o_gain;
    logic [2:0]  o_phase_at_entry;
    logic [2:0]  o_phase_now;

    adsr_envelope_generator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_kind(i_kind), .i_sample_count(i_sample_count),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_gain(o_gain), .o_phase_at_entry(o_phase_at_entry), .o_phase_now(o_phase_now)
    );

    always #4 i_clk = ~i_clk;

    typedef struct {
        logic [14:0] gain;
        t_phase      entry;
        t_phase      now;
    } t_env_out;

    t_env_out env_expected[$];
    int       error_count = 0;
    int       snd_idle = 0;
    int       rcv_idle = 0;
    int       rcv_hold = 0;
    int       quiet_cycles = 0;

    // envelope model state and settings
    logic [23:0] len_attack, len_decay, len_sustain, len_release;
    logic [14:0] sus_level;
    logic        square_on;
    t_phase      env_phase;
    logic [23:0] env_remaining;
    longint      env_acc;
    longint      env_step;
    int          env_level;

    function automatic longint clamp_acc(longint a);
        if (a < 0) a = 0;
        if (a > FULL_ACC) a = FULL_ACC;
        return a;
    endfunction

    function automatic void begin_release();
        env_phase = PH_RELEASE;
        env_remaining = len_release;
        env_acc = clamp_acc(longint'(env_level) <<< FRAC_BITS);
        if (len_release != 0) begin
            env_step = -((longint'(env_level) <<< FRAC_BITS) / longint'(len_release));
        end else begin
            env_step = 0;
            env_acc = 0;
        end
        env_level = int'(env_acc >>> FRAC_BITS);
    endfunction

    function automatic void begin_attack();
        env_phase = PH_ATTACK;
        env_remaining = len_attack;
        env_acc = 0;
        if (len_attack != 0) begin
            env_step = FULL_ACC / longint'(len_attack);
        end else begin
            env_step = 0;
            env_acc = FULL_ACC;
        end
        env_level = int'(env_acc >>> FRAC_BITS);
    endfunction

    function automatic bit enter_next_phase();
        longint sus;
        sus = longint'(sus_level);
        case (env_phase)
            PH_ATTACK: begin
                env_phase = PH_DECAY;
                env_remaining = len_decay;
                env_acc = clamp_acc(longint'(env_level) <<< FRAC_BITS);
                if (len_decay != 0) begin
                    env_step = ((sus - env_level) <<< FRAC_BITS) / longint'(len_decay);
                end else begin
                    env_step = 0;
                    env_acc = sus <<< FRAC_BITS;
                end
                env_level = int'(env_acc >>> FRAC_BITS);
                return 1'b1;
            end
            PH_DECAY: begin
                env_phase = PH_SUSTAIN;
                env_remaining = len_sustain;
                env_acc = sus <<< FRAC_BITS;
                env_step = 0;
                env_level = int'(sus);
                return 1'b1;
            end
            PH_SUSTAIN: begin
                if (len_sustain == 0) return 1'b0;
                begin_release();
                return 1'b1;
            end
            PH_RELEASE: begin
                env_phase = PH_END;
                env_remaining = '0;
                env_acc = 0;
                env_step = 0;
                env_level = 0;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic void advance_env(logic [23:0] count);
        longint used;
        longint a;
        longint sus;
        used = longint'(count);
        sus = longint'(sus_level) <<< FRAC_BITS;
        if (env_phase == PH_END) begin
            env_remaining = '0;
            return;
        end
        while (env_remaining == 0 && env_phase != PH_END) begin
            if (!enter_next_phase()) break;
        end
        if (env_phase == PH_END) begin
            env_remaining = '0;
            return;
        end
        if (used >= env_remaining) begin
            used = env_remaining;
            env_remaining = '0;
        end else begin
            env_remaining = env_remaining - used[23:0];
        end
        if (env_phase == PH_SUSTAIN) begin
            env_level = int'(sus_level);
        end else begin
            a = env_acc + env_step * used;
            if (env_phase == PH_ATTACK) begin
                if (a > FULL_ACC) a = FULL_ACC;
            end else if (env_phase == PH_DECAY) begin
                if (env_step < 0 && a < sus) a = sus;
                else if (env_step > 0 && a > sus) a = sus;
            end else begin
                if (a < 0) a = 0;
            end
            env_acc = clamp_acc(a);
            env_level = int'(env_acc >>> FRAC_BITS);
        end
        if (square_on) env_level = (env_level * env_level) >>> 15;
    endfunction

    function automatic t_env_out envelope_step(logic [1:0] kind, logic [23:0] count);
        t_env_out r;
        r.entry = env_phase;
        case (kind)
            KIND_ADVANCE:  advance_env(count);
            KIND_NOTE_ON:  begin_attack();
            KIND_NOTE_OFF: begin_release();
            default: ;
        endcase
        r.gain = env_level[14:0];
        r.now = env_phase;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_env_out e;
        if (i_rst_n && o_valid && i_ready) begin
            if (env_expected.size() == 0) begin
                report_mismatch("pending item count", 1, 0);
            end else begin
                e = env_expected.pop_front();
                if (o_gain !== e.gain) report_mismatch("gain", o_gain, e.gain);
                if (o_phase_at_entry !== e.entry)
                    report_mismatch("phase_at_entry", o_phase_at_entry, e.entry);
                if (o_phase_now !== e.now) report_mismatch("phase_now", o_phase_now, e.now);
            end
        end
    end

    always @(posedge i_clk) begin
        if (rcv_hold > 0) begin
            rcv_hold <= rcv_hold - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic send_item(logic [1:0] kind, logic [23:0] count, bit typed, t_env_out want);
        t_env_out p;
        while ($urandom_range(99) < snd_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_sample_count <= count;
        do @(posedge i_clk); while (!o_ready);
        p = envelope_step(kind, count);
        env_expected.push_back(typed ? want : p);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        wait (env_expected.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_ATTACK:  len_attack = data;
            CFG_DECAY:   len_decay = data;
            CFG_SUSTAIN: len_sustain = data;
            CFG_RELEASE: len_release = data;
            CFG_SUS_LVL: sus_level = data[14:0];
            CFG_SQUARE:  square_on = data[0];
            default: ;
        endcase
    endtask

    task automatic apply_cfg(logic [23:0] a, logic [23:0] d, logic [23:0] s,
                             logic [23:0] r, logic [14:0] lvl, logic sq);
        drain();
        write_reg(CFG_ATTACK, a);
        write_reg(CFG_DECAY, d);
        write_reg(CFG_SUSTAIN, s);
        write_reg(CFG_RELEASE, r);
        write_reg(CFG_SUS_LVL, {9'd0, lvl});
        write_reg(CFG_SQUARE, {23'd0, sq});
    endtask

    function automatic logic [23:0] rand_length();
        int r;
        r = $urandom_range(99);
        if (r < 15) return 24'd0;
        if (r < 20) return 24'hFFFFFF;
        if (r < 25) return 24'($urandom_range(24'hFFFFFF));
        return 24'($urandom_range(1, 24));
    endfunction

    function automatic logic [23:0] rand_count();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 24'd0;
        if (r < 18) return 24'($urandom_range(24'hFFFFFF));
        if (r < 22) return 24'hFFFFFF;
        return 24'($urandom_range(1, 12));
    endfunction

    typedef struct {
        int          grp;
        logic [1:0]  kind;
        logic [23:0] count;
        bit          typed;
        logic [14:0] gain;
        t_phase      entry;
        t_phase      now;
    } t_row;

    t_row rows[] = '{
        '{0, KIND_ADVANCE,  24'd0,       1, 15'd0,     PH_END,     PH_END},
        '{0, KIND_NOTE_ON,  24'd0,       1, 15'h7FFF,  PH_END,     PH_ATTACK},
        '{0, KIND_ADVANCE,  24'd5,       1, 15'd0,     PH_ATTACK,  PH_SUSTAIN},
        '{0, KIND_NOTE_OFF, 24'd0,       1, 15'd0,     PH_SUSTAIN, PH_RELEASE},
        '{0, KIND_ADVANCE,  24'd1,       1, 15'd0,     PH_RELEASE, PH_END},
        '{0, KIND_UNUSED,   24'hFFFFFF,  1, 15'd0,     PH_END,     PH_END},
        '{1, KIND_NOTE_ON,  24'd0,       0, 15'd0,     PH_END,     PH_END},
        '{1, KIND_ADVANCE,  24'd1,       0, 15'd0,     PH_END,     PH_END},
        '{1, KIND_ADVANCE,  24'd2,       0, 15'd0,     PH_END,     PH_END},
        '{1, KIND_ADVANCE,  24'd100,     0, 15'd0,     PH_END,     PH_END},
        '{1, KIND_ADVANCE,  24'd0,       0, 15'd0,     PH_END,     PH_END},
        '{1, KIND_ADVANCE,  24'd2,       0, 15'd0,     PH_END,     PH_END},
        '{1, KIND_NOTE_OFF, 24'd0,       0, 15'd0,     PH_END,     PH_END},
        '{1, KIND_ADVANCE,  24'hFFFFFF,  0, 15'd0,     PH_END,     PH_END},
        '{1, KIND_ADVANCE,  24'd5,       0, 15'd0,     PH_END,     PH_END},
        '{1, KIND_UNUSED,   24'd0,       0, 15'd0,     PH_END,     PH_END},
        '{2, KIND_NOTE_ON,  24'd0,       0, 15'd0,     PH_END,     PH_END},
        '{2, KIND_ADVANCE,  24'hFFFFFF,  0, 15'd0,     PH_END,     PH_END},
        '{2, KIND_ADVANCE,  24'd1,       0, 15'd0,     PH_END,     PH_END},
        '{2, KIND_ADVANCE,  24'd7,       0, 15'd0,     PH_END,     PH_END},
        '{2, KIND_NOTE_OFF, 24'd0,       0, 15'd0,     PH_END,     PH_END},
        '{2, KIND_ADVANCE,  24'd3,       0, 15'd0,     PH_END,     PH_END},
        '{2, KIND_ADVANCE,  24'hFFFFFF,  0, 15'd0,     PH_END,     PH_END}
    };

    initial begin
        t_env_out want;
        int grp;
        int sent;
        int burst;
        int r;

        len_attack = 0; len_decay = 0; len_sustain = 0; len_release = 0;
        sus_level = 0; square_on = 0;
        env_phase = PH_END; env_remaining = 0;
        env_acc = 0; env_step = 0; env_level = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        grp = 0;
        foreach (rows[i]) begin
            if (rows[i].grp != grp) begin
                grp = rows[i].grp;
                if (grp == 1) apply_cfg(24'd4, 24'd4, 24'd3, 24'd4, 15'd16384, 1'b0);
                else apply_cfg(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 15'h7FFF, 1'b1);
            end
            want.gain = rows[i].gain;
            want.entry = rows[i].entry;
            want.now = rows[i].now;
            send_item(rows[i].kind, rows[i].count, rows[i].typed, want);
        end

        // long receiver stall while items keep coming, then a full pause
        apply_cfg(24'd3, 24'd2, 24'd2, 24'd3, 15'd9000, 1'b0);
        rcv_hold = 600;
        repeat (12) send_item(KIND_ADVANCE, 24'($urandom_range(0, 3)), 1'b0, want);
        drain();

        sent = 0;
        while (sent < 1700) begin
            if (sent < 570) begin
                snd_idle = 33; rcv_idle = 50;
            end else if (sent < 1140) begin
                snd_idle = 50; rcv_idle = 33;
            end else begin
                snd_idle = 0; rcv_idle = 0;
            end
            if ($urandom_range(99) < 8) begin
                apply_cfg(rand_length(), rand_length(), rand_length(), rand_length(),
                          ($urandom_range(99) < 20) ? 15'h7FFF : 15'($urandom()),
                          1'($urandom()));
            end
            r = $urandom_range(99);
            if (r < 8) begin
                send_item(2'($urandom()), 24'($urandom()), 1'b0, want);
                sent++;
            end else begin
                send_item(KIND_NOTE_ON, 24'($urandom()), 1'b0, want);
                sent++;
                burst = $urandom_range(1, 8);
                repeat (burst) send_item(KIND_ADVANCE, rand_count(), 1'b0, want);
                sent += burst;
                if ($urandom_range(99) < 85) begin
                    send_item(KIND_NOTE_OFF, 24'($urandom()), 1'b0, want);
                    sent++;
                end
                burst = $urandom_range(0, 4);
                repeat (burst) send_item(KIND_ADVANCE, rand_count(), 1'b0, want);
                sent += burst;
            end
        end

        drain();
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
sv/adsr_pkg.sv
sv/adsr_div.sv
sv/adsr_dp.sv
sv/adsr_ctrl.sv
sv/adsr_envelope_generator.sv
test/tb.sv
